[rtl/core/pwc_pkg.sv]
// ============================================================================
// pwc_pkg
// Shared types, widths and helper functions of the page-walk cache.
// ============================================================================
package pwc_pkg;

    localparam int KEY_W       = 52;
    localparam int ACT_W       = 2;
    localparam int LVL_W       = 2;
    localparam int ENTRY_SHIFT = 3;
    localparam int IDX_W       = KEY_W - ENTRY_SHIFT;

    localparam int LEVELS_DEF  = 4;
    localparam int SETS_DEF    = 16;
    localparam int WAYS_DEF    = 4;
    localparam int AGE_W_DEF   = 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_INVAL  = 2'd2,
        ACT_FLUSH  = 2'd3
    } t_action;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [LVL_W-1:0] table_level;
        logic [KEY_W-1:0] key_addr;
        logic [KEY_W-1:0] write_value;
    } t_in_beat;

    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] read_value;
    } t_out_beat;

    typedef struct packed {
        logic hit;
        logic wr_en;
    } t_upd_status;

    // Tag width: the entry index divided by the set count.
    function automatic int f_tag_w(input int sets);
        return IDX_W + 1 - $clog2(sets + 1);
    endfunction

    // One way of a row: valid, tag, value, age.
    function automatic int f_entry_w(input int sets, input int age_w);
        return 1 + f_tag_w(sets) + KEY_W + age_w;
    endfunction

endpackage

[rtl/core/pwc_ram.sv]
// ============================================================================
// pwc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module pwc_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 2,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/pwc_split.sv]
// ============================================================================
// pwc_split
// Splits a PTE byte address into set index and tag. A power-of-two set count
// is a registered bit split; any other count multiplies the entry index by a
// rounded-up reciprocal of the set count, one partial product per cycle.
// ============================================================================
module pwc_split #(
    parameter int  SETS  = pwc_pkg::SETS_DEF,
    localparam int SET_W = $clog2(SETS),
    localparam int TAG_W = pwc_pkg::f_tag_w(SETS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [pwc_pkg::KEY_W-1:0] i_key,
    output logic                     o_done,
    output logic [SET_W-1:0]         o_set,
    output logic [TAG_W-1:0]         o_tag
);
    import pwc_pkg::*;

    logic [IDX_W-1:0] idx;

    assign idx = i_key[KEY_W-1:ENTRY_SHIFT];

    if ((SETS & (SETS - 1)) == 0) begin : g_pow2
        logic             r_done;
        logic [SET_W-1:0] r_set;
        logic [TAG_W-1:0] r_tag;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
                if (i_start) begin
                    r_set <= idx[SET_W-1:0];
                    r_tag <= idx[IDX_W-1:SET_W];
                end
            end
        end

        assign o_done = r_done;
        assign o_set  = r_set;
        assign o_tag  = r_tag;
    end else begin : g_div
        // The quotient is the index times ceil(2^SHIFT / SETS), shifted down by
        // SHIFT; this is exact for every index below 2^IDX_W.
        localparam int HALF   = (IDX_W + 1) / 2;
        localparam int PROD_W = 4 * HALF;
        localparam int SHIFT  = IDX_W + SET_W;
        localparam logic [63:0] MAGIC = ((64'd1 << SHIFT) + 64'(SETS - 1)) / 64'(SETS);
        localparam logic [HALF-1:0] M_LO = MAGIC[HALF-1:0];
        localparam logic [HALF-1:0] M_HI = MAGIC[2*HALF-1:HALF];

        logic               r_busy;
        logic               r_done;
        logic [2:0]         r_step;
        logic [2*HALF-1:0]  r_x;
        logic [PROD_W-1:0]  r_acc;
        logic [SET_W-1:0]   r_set;
        logic [TAG_W-1:0]   r_tag;
        logic [HALF-1:0]    x_half;
        logic [HALF-1:0]    m_half;
        logic [2*HALF-1:0]  part;
        logic [PROD_W-1:0]  addend;
        logic [TAG_W-1:0]   quo;
        logic [2*SET_W-1:0] qd;
        logic [SET_W-1:0]   rem;

        // Steps 0 to 3 take low*low, low*high, high*low and high*high halves.
        assign x_half = r_step[1] ? r_x[2*HALF-1:HALF] : r_x[HALF-1:0];
        assign m_half = r_step[0] ? M_HI : M_LO;
        assign part   = (2*HALF)'(x_half) * (2*HALF)'(m_half);

        always_comb begin
            case (r_step[1:0])
                2'd0:    addend = PROD_W'(part);
                2'd3:    addend = {part, {(2*HALF){1'b0}}};
                default: addend = {{HALF{1'b0}}, part, {HALF{1'b0}}};
            endcase
        end

        // The remainder is below 2^SET_W, so the low bits of the
        // difference are enough.
        assign quo = r_acc[SHIFT +: TAG_W];
        assign qd  = (2*SET_W)'(quo[SET_W-1:0]) * (2*SET_W)'(SETS);
        assign rem = r_x[SET_W-1:0] - qd[SET_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy <= 1'b0;
                r_done <= 1'b0;
            end else begin
                r_done <= 1'b0;
                if (i_start) begin
                    r_busy <= 1'b1;
                    r_step <= '0;
                    r_x    <= (2*HALF)'(idx);
                    r_acc  <= '0;
                end else if (r_busy) begin
                    if (r_step == 3'd4) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_set  <= rem;
                        r_tag  <= quo;
                    end else begin
                        r_acc  <= r_acc + addend;
                        r_step <= r_step + 3'd1;
                    end
                end
            end
        end

        assign o_done = r_done;
        assign o_set  = r_set;
        assign o_tag  = r_tag;
    end

    a_set_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ({1'b0, o_set} < (SET_W+1)'(SETS)))
        else $error("set index out of range");

endmodule

[rtl/core/pwc_set_update.sv]
// ============================================================================
// pwc_set_update
// Read-modify-write logic for one cache row (all ways of one set): tag match,
// victim choice, age refresh and the answer of the operation.
// ============================================================================
module pwc_set_update #(
    parameter int  SETS  = pwc_pkg::SETS_DEF,
    parameter int  WAYS  = pwc_pkg::WAYS_DEF,
    parameter int  AGE_W = pwc_pkg::AGE_W_DEF,
    localparam int TAG_W = pwc_pkg::f_tag_w(SETS),
    localparam int E_W   = pwc_pkg::f_entry_w(SETS, AGE_W),
    localparam int ROW_D = WAYS * E_W
) (
    input  logic                      i_level_ok,
    input  pwc_pkg::t_action          i_act,
    input  logic [TAG_W-1:0]          i_tag,
    input  logic [pwc_pkg::KEY_W-1:0] i_wval,
    input  logic [ROW_D-1:0]          i_row,
    output logic [ROW_D-1:0]          o_row,
    output logic [pwc_pkg::KEY_W-1:0] o_read_value,
    output pwc_pkg::t_upd_status      o_status
);
    import pwc_pkg::*;

    localparam int P2    = 1 << $clog2(WAYS);
    localparam int WAY_W = (P2 > 1) ? $clog2(P2) : 1;

    logic             vld   [P2];
    logic [TAG_W-1:0] tags  [P2];
    logic [KEY_W-1:0] vals  [P2];
    logic [AGE_W-1:0] ages  [P2];
    logic             n_vld [P2];
    logic [TAG_W-1:0] n_tag [P2];
    logic [KEY_W-1:0] n_val [P2];
    logic [AGE_W-1:0] n_age [P2];
    logic [AGE_W-1:0] tr_age [2*P2-1];
    logic [WAY_W-1:0] tr_idx [2*P2-1];
    logic             any_hit;
    logic             any_inv;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] inv_way;
    logic [WAY_W-1:0] tgt;

    // Ways beyond WAYS pad the age tree only; they are never valid.
    for (genvar w = 0; w < P2; w++) begin : g_unpack
        if (w < WAYS) begin : g_real
            assign vld[w]  = i_row[w*E_W + E_W - 1];
            assign tags[w] = i_row[w*E_W + AGE_W + KEY_W +: TAG_W];
            assign vals[w] = i_row[w*E_W + AGE_W +: KEY_W];
            assign ages[w] = i_row[w*E_W +: AGE_W];
            assign o_row[w*E_W +: E_W] = {n_vld[w], n_tag[w], n_val[w], n_age[w]};
        end else begin : g_pad
            assign vld[w]  = 1'b0;
            assign tags[w] = '0;
            assign vals[w] = '0;
            assign ages[w] = '0;
        end
    end

    // Lowest-indexed matching way and lowest-indexed free way.
    always_comb begin
        any_hit = 1'b0;
        any_inv = 1'b0;
        hit_way = '0;
        inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (vld[w] && (tags[w] == i_tag)) begin
                any_hit = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!vld[w]) begin
                any_inv = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
    end

    // Oldest way by a balanced tree; the left child wins ties.
    always_comb begin
        for (int i = 0; i < P2; i++) begin
            tr_age[P2-1+i] = ages[i];
            tr_idx[P2-1+i] = WAY_W'(i);
        end
        for (int n = P2 - 2; n >= 0; n--) begin
            if (tr_age[2*n+2] > tr_age[2*n+1]) begin
                tr_age[n] = tr_age[2*n+2];
                tr_idx[n] = tr_idx[2*n+2];
            end else begin
                tr_age[n] = tr_age[2*n+1];
                tr_idx[n] = tr_idx[2*n+1];
            end
        end
    end

    assign tgt = any_hit ? hit_way : (any_inv ? inv_way : tr_idx[0]);

    always_comb begin
        logic do_touch;
        do_touch     = 1'b0;
        o_status     = '0;
        o_read_value = '0;
        for (int w = 0; w < P2; w++) begin
            n_vld[w] = vld[w];
            n_tag[w] = tags[w];
            n_val[w] = vals[w];
            n_age[w] = ages[w];
        end
        if (i_level_ok) begin
            case (i_act)
                ACT_LOOKUP: begin
                    if (any_hit) begin
                        o_status.hit   = 1'b1;
                        o_status.wr_en = 1'b1;
                        o_read_value   = vals[hit_way];
                        do_touch       = 1'b1;
                    end
                end
                ACT_INSERT: begin
                    o_status.hit   = any_hit;
                    o_status.wr_en = 1'b1;
                    n_vld[tgt]     = 1'b1;
                    n_tag[tgt]     = i_tag;
                    n_val[tgt]     = i_wval;
                    do_touch       = 1'b1;
                end
                ACT_INVAL: begin
                    if (any_hit) begin
                        o_status.hit   = 1'b1;
                        o_status.wr_en = 1'b1;
                        n_vld[hit_way] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
        if (do_touch) begin
            for (int w = 0; w < WAYS; w++) begin
                if (WAY_W'(w) == tgt) begin
                    n_age[w] = '0;
                end else if (vld[w] && (ages[w] != {AGE_W{1'b1}})) begin
                    n_age[w] = ages[w] + AGE_W'(1);
                end
            end
        end
    end

endmodule

[rtl/core/page_walk_cache_lru.sv]
// ============================================================================
// page_walk_cache_lru
// Page-walk cache with one set-associative table per walk level and
// age-counter LRU replacement. All state sits in one row-wide RAM, one row
// per (level, set) holding every way's valid bit, tag, next-level base and
// age. An item is accepted only while the block is idle; it splits its key
// into set and tag, reads the row, and then writes the updated row back in
// the same cycle as its result enters the output register. A power-of-two
// SETS splits the key by a bit split; other set counts split it by a
// reciprocal multiplication instead. A flush rewrites every row and then
// registers its result once the output register is free. After reset the
// same all-row clearing pass runs before the first item is taken.
// A waiting result does not stop the next item from entering, but that item
// holds in its access cycle until the output register is free.
// ============================================================================
module page_walk_cache_lru #(
    parameter int LEVELS    = pwc_pkg::LEVELS_DEF,
    parameter int SETS      = pwc_pkg::SETS_DEF,
    parameter int WAYS      = pwc_pkg::WAYS_DEF,
    parameter int AGE_WIDTH = pwc_pkg::AGE_W_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pwc_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pwc_pkg::t_out_beat o_out_beat
);
    import pwc_pkg::*;

    localparam int ROWS  = LEVELS * SETS;
    localparam int ROW_W = $clog2(ROWS);
    localparam int SET_W = $clog2(SETS);
    localparam int TAG_W = f_tag_w(SETS);
    localparam int ROW_D = WAYS * f_entry_w(SETS, AGE_WIDTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_ACCESS,
        ST_FLUSH,
        ST_FDONE
    } t_state;

    t_state     r_state, n_state;
    t_in_beat   r_item, n_item;
    t_out_beat  r_out_beat, n_out_beat;
    logic       r_out_valid, n_out_valid;
    logic [ROW_W-1:0] r_clr_row, n_clr_row;
    logic [ROW_W-1:0] r_row, n_row;
    logic       r_level_ok, n_level_ok;
    logic [TAG_W-1:0] r_tag, n_tag;

    logic             in_acc;
    logic             out_free;
    logic             level_ok_c;
    logic             split_start;
    logic             split_done;
    logic [SET_W-1:0] split_set;
    logic [TAG_W-1:0] split_tag;
    logic [ROW_W-1:0] rd_row;
    logic             ram_we;
    logic [ROW_W-1:0] ram_waddr;
    logic [ROW_D-1:0] ram_wdata;
    logic [ROW_D-1:0] ram_rdata;
    logic [ROW_D-1:0] upd_row;
    logic [KEY_W-1:0] upd_rval;
    t_upd_status      upd_status;
    logic             sweep;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign split_start = in_acc && (i_in_beat.action != ACT_FLUSH);
    assign sweep       = (r_state == ST_CLEAR) || (r_state == ST_FLUSH);

    assign level_ok_c = ({1'b0, r_item.table_level} < 3'(LEVELS));
    assign rd_row     = level_ok_c
        ? ROW_W'((ROW_W+1)'(r_item.table_level) * (ROW_W+1)'(SETS) + (ROW_W+1)'(split_set))
        : '0;

    pwc_split #(
        .SETS (SETS)
    ) u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (split_start),
        .i_key   (i_in_beat.key_addr),
        .o_done  (split_done),
        .o_set   (split_set),
        .o_tag   (split_tag)
    );

    pwc_ram #(
        .WIDTH (ROW_D),
        .DEPTH (ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (split_done),
        .i_raddr (rd_row),
        .o_rdata (ram_rdata)
    );

    pwc_set_update #(
        .SETS  (SETS),
        .WAYS  (WAYS),
        .AGE_W (AGE_WIDTH)
    ) u_upd (
        .i_level_ok   (r_level_ok),
        .i_act        (t_action'(r_item.action)),
        .i_tag        (r_tag),
        .i_wval       (r_item.write_value),
        .i_row        (ram_rdata),
        .o_row        (upd_row),
        .o_read_value (upd_rval),
        .o_status     (upd_status)
    );

    // Rows are rewritten all-zero during the clearing pass and a flush.
    assign ram_we    = sweep || ((r_state == ST_ACCESS) && out_free && upd_status.wr_en);
    assign ram_waddr = sweep ? r_clr_row : r_row;
    assign ram_wdata = sweep ? '0 : upd_row;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_out_beat  = r_out_beat;
        n_out_valid = r_out_valid && !i_out_ready;
        n_clr_row   = r_clr_row;
        n_row       = r_row;
        n_level_ok  = r_level_ok;
        n_tag       = r_tag;
        unique case (r_state)
            ST_CLEAR, ST_FLUSH: begin
                n_clr_row = r_clr_row + ROW_W'(1);
                if (r_clr_row == ROW_W'(ROWS - 1)) begin
                    n_clr_row = '0;
                    n_state   = (r_state == ST_CLEAR) ? ST_IDLE : ST_FDONE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_item  = i_in_beat;
                    n_state = (i_in_beat.action == ACT_FLUSH) ? ST_FLUSH : ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                if (split_done) begin
                    n_row      = rd_row;
                    n_level_ok = level_ok_c;
                    n_tag      = split_tag;
                    n_state    = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_beat.hit        = upd_status.hit;
                    n_out_beat.read_value = upd_rval;
                    n_state               = ST_IDLE;
                end
            end
            ST_FDONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_beat  = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
            r_clr_row   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_clr_row   <= n_clr_row;
            r_item      <= n_item;
            r_out_beat  <= n_out_beat;
            r_row       <= n_row;
            r_level_ok  <= n_level_ok;
            r_tag       <= n_tag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !ram_we)
        else $error("row written while idle");

    a_split_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        split_start |=> (r_state == ST_SPLIT))
        else $error("accepted beat did not start the key split");

    a_split_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        split_done |-> (r_state == ST_SPLIT))
        else $error("key split finished outside the split state");

    a_load_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_ACCESS || $past(r_state) == ST_FDONE))
        else $error("result loaded from an unexpected state");

endmodule

[tb/page_walk_cache_lru_test.sv]
`timescale 1ns / 100ps
// ============================================================================
// page_walk_cache_lru_test
// Self-checking bench for the page-walk cache. A behavioral copy of the
// tables (valid, tag, base, age per way) predicts every response beat at
// the moment its request beat is accepted. Directed cases, an age
// saturation run, random traffic under three idling mixes and a long
// output stall are applied in turn.
// ============================================================================
module page_walk_cache_lru_test;
    import pwc_pkg::*;

    localparam int LEVELS = LEVELS_DEF;
    localparam int SETS   = SETS_DEF;
    localparam int WAYS   = WAYS_DEF;
    localparam int AGE_W  = AGE_W_DEF;
    localparam int SET_W  = $clog2(SETS);
    localparam int TAG_W  = IDX_W - SET_W;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_beat out_beat;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;
    int mismatch_cnt  = 0;

    // Behavioral copy of the cache tables.
    logic             line_valid [LEVELS][SETS][WAYS];
    logic [TAG_W-1:0] line_tag   [LEVELS][SETS][WAYS];
    logic [KEY_W-1:0] line_base  [LEVELS][SETS][WAYS];
    logic [AGE_W-1:0] line_age   [LEVELS][SETS][WAYS];

    t_out_beat resp_q[$];
    t_out_beat resp_want;

    page_walk_cache_lru u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("page_walk_cache_lru verification failed");
        $finish;
    end

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[KEY_W-1:0];
    endfunction

    function automatic logic [TAG_W-1:0] rand_tag();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TAG_W-1:0];
    endfunction

    function automatic logic [KEY_W-1:0] mk_key(input logic [TAG_W-1:0] tg, input int st,
                                               input logic [2:0] low);
        logic [SET_W-1:0] s;
        s = st[SET_W-1:0];
        return {tg, s, low};
    endfunction

    function automatic t_in_beat mk_beat(input t_action a, input int lv,
                                         input logic [KEY_W-1:0] key,
                                         input logic [KEY_W-1:0] val);
        t_in_beat b;
        b.action      = a;
        b.table_level = lv[LVL_W-1:0];
        b.key_addr    = key;
        b.write_value = val;
        return b;
    endfunction

    // An access zeroes the touched way and ages every other valid way.
    function automatic void age_refresh(input int lv, input int st, input int way);
        for (int w = 0; w < WAYS; w++) begin
            if (w != way && line_valid[lv][st][w] && line_age[lv][st][w] != '1)
                line_age[lv][st][w] = line_age[lv][st][w] + AGE_W'(1);
        end
        line_age[lv][st][way] = '0;
    endfunction

    function automatic int evict_way(input int lv, input int st);
        int               best;
        logic [AGE_W-1:0] best_age;
        for (int w = 0; w < WAYS; w++) begin
            if (!line_valid[lv][st][w])
                return w;
        end
        best     = 0;
        best_age = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (line_age[lv][st][w] > best_age) begin
                best_age = line_age[lv][st][w];
                best     = w;
            end
        end
        return best;
    endfunction

    function automatic t_out_beat cache_access(input t_in_beat b);
        t_out_beat        r;
        logic [IDX_W-1:0] idx;
        logic [TAG_W-1:0] tg;
        int               st;
        int               lv;
        int               hit_way;
        int               v;
        r   = '0;
        idx = b.key_addr[KEY_W-1:ENTRY_SHIFT];
        st  = int'(idx % SETS);
        tg  = TAG_W'(idx / SETS);
        lv  = int'(b.table_level);
        if (t_action'(b.action) == ACT_FLUSH) begin
            foreach (line_valid[i, j, k])
                line_valid[i][j][k] = 1'b0;
        end else if (lv < LEVELS) begin
            hit_way = -1;
            for (int w = WAYS - 1; w >= 0; w--) begin
                if (line_valid[lv][st][w] && line_tag[lv][st][w] == tg)
                    hit_way = w;
            end
            case (t_action'(b.action))
                ACT_LOOKUP: begin
                    if (hit_way >= 0) begin
                        r.hit        = 1'b1;
                        r.read_value = line_base[lv][st][hit_way];
                        age_refresh(lv, st, hit_way);
                    end
                end
                ACT_INSERT: begin
                    if (hit_way >= 0) begin
                        r.hit = 1'b1;
                        line_base[lv][st][hit_way] = b.write_value;
                        age_refresh(lv, st, hit_way);
                    end else begin
                        v = evict_way(lv, st);
                        line_valid[lv][st][v] = 1'b1;
                        line_tag[lv][st][v]   = tg;
                        line_base[lv][st][v]  = b.write_value;
                        line_age[lv][st][v]   = '0;
                        age_refresh(lv, st, v);
                    end
                end
                default: begin
                    if (hit_way >= 0) begin
                        r.hit = 1'b1;
                        line_valid[lv][st][hit_way] = 1'b0;
                    end
                end
            endcase
        end
        return r;
    endfunction

    // Offers one request beat, holding it until accepted, and records its predicted response.
    task automatic send_req(input t_in_beat b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (!in_ready);
        resp_q = {resp_q, cache_access(b)};
    endtask

    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_ready <= 1'b0;
            hold_cycles--;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (resp_q.size() == 0) begin
                $error("response beat with no request outstanding");
                mismatch_cnt++;
            end else begin
                resp_want = resp_q.pop_front();
                if (out_beat.hit !== resp_want.hit) begin
                    $error("hit: expected %0d, got %0d", resp_want.hit, out_beat.hit);
                    mismatch_cnt++;
                end
                if (out_beat.read_value !== resp_want.read_value) begin
                    $error("read_value: expected %h, got %h",
                           resp_want.read_value, out_beat.read_value);
                    mismatch_cnt++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [KEY_W-1:0] ones;
        ones = '1;
        send_req(mk_beat(ACT_LOOKUP, 0, '0, '0));
        send_req(mk_beat(ACT_INSERT, 0, '0, ones));
        // The byte offset inside an 8-byte entry does not take part in the key.
        send_req(mk_beat(ACT_LOOKUP, 0, 52'd7, '0));
        send_req(mk_beat(ACT_INSERT, 3, ones, '0));
        send_req(mk_beat(ACT_LOOKUP, 3, ones, ones));
        send_req(mk_beat(ACT_INSERT, 3, ones, 52'h5_5555_5555_5555));
        send_req(mk_beat(ACT_LOOKUP, 3, ones, '0));
        send_req(mk_beat(ACT_LOOKUP, 2, ones, '0));
        // Fill one set, refresh one way, then force an eviction.
        for (int t = 1; t <= 4; t++)
            send_req(mk_beat(ACT_INSERT, 1, mk_key(TAG_W'(t), 0, 3'd0), rand_key()));
        send_req(mk_beat(ACT_LOOKUP, 1, mk_key(TAG_W'(2), 0, 3'd0), '0));
        send_req(mk_beat(ACT_INSERT, 1, mk_key(TAG_W'(5), 0, 3'd0), rand_key()));
        send_req(mk_beat(ACT_LOOKUP, 1, mk_key(TAG_W'(1), 0, 3'd0), '0));
        send_req(mk_beat(ACT_LOOKUP, 1, mk_key(TAG_W'(5), 0, 3'd0), '0));
        send_req(mk_beat(ACT_INVAL, 1, mk_key(TAG_W'(3), 0, 3'd0), ones));
        send_req(mk_beat(ACT_INVAL, 1, mk_key(TAG_W'(3), 0, 3'd0), '0));
        // The freed way is taken before any aged one.
        send_req(mk_beat(ACT_INSERT, 1, mk_key(TAG_W'(6), 0, 3'd0), rand_key()));
        send_req(mk_beat(ACT_LOOKUP, 1, mk_key(TAG_W'(6), 0, 3'd0), '0));
        send_req(mk_beat(ACT_FLUSH, 2, ones, ones));
        send_req(mk_beat(ACT_LOOKUP, 0, '0, '0));
        send_req(mk_beat(ACT_INVAL, 3, ones, '0));
    endtask

    // Hammering one way drives the others to the saturated age, so the victim
    // is picked by index among equal ages.
    task automatic test_age_saturation();
        logic [TAG_W-1:0] base_tag;
        base_tag = rand_tag() & ~TAG_W'(7);
        for (int t = 0; t < 4; t++)
            send_req(mk_beat(ACT_INSERT, 2, mk_key(base_tag | TAG_W'(t), 5, 3'd0), rand_key()));
        repeat (260)
            send_req(mk_beat(ACT_LOOKUP, 2, mk_key(base_tag, 5, 3'($urandom)), rand_key()));
        send_req(mk_beat(ACT_INSERT, 2, mk_key(base_tag | TAG_W'(4), 5, 3'd0), rand_key()));
        for (int t = 0; t <= 4; t++)
            send_req(mk_beat(ACT_LOOKUP, 2, mk_key(base_tag | TAG_W'(t), 5, 3'd0), '0));
    endtask

    // Small tag pools per phase keep the sets contended so hits, overwrites
    // and evictions all happen often.
    task automatic random_beats(input int n_items);
        logic [TAG_W-1:0] tag_pool[8];
        logic [TAG_W-1:0] tg;
        logic [KEY_W-1:0] key;
        t_action          act;
        int               roll;
        int               st;
        foreach (tag_pool[i])
            tag_pool[i] = rand_tag();
        repeat (n_items) begin
            roll = $urandom_range(99);
            if (roll < 2)
                act = ACT_FLUSH;
            else if (roll < 47)
                act = ACT_LOOKUP;
            else if (roll < 82)
                act = ACT_INSERT;
            else
                act = ACT_INVAL;
            st  = $urandom_range(1) ? $urandom_range(1) : $urandom_range(SETS - 1);
            tg  = ($urandom_range(19) == 0) ? rand_tag() : tag_pool[$urandom_range(7)];
            key = mk_key(tg, st, 3'($urandom));
            if ($urandom_range(49) == 0)
                key = rand_key();
            send_req(mk_beat(act, $urandom_range(LEVELS - 1), key, rand_key()));
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        random_beats(380);
    endtask

    // The output side stops for a long stretch while requests keep coming.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 400;
        random_beats(40);
    endtask

    initial begin
        foreach (line_valid[i, j, k]) begin
            line_valid[i][j][k] = 1'b0;
            line_age[i][j][k]   = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 23;
        recv_idle_pct = 66;
        test_directed();
        test_age_saturation();
        test_random_traffic(23, 66);
        test_random_traffic(66, 23);
        test_random_traffic(0, 0);
        test_backpressure();
        @(negedge clk);
        in_valid <= 1'b0;
        while (resp_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_cnt == 0) begin
            $display("page_walk_cache_lru verification clean");
        end else begin
            $display("page_walk_cache_lru verification failed");
        end
        $finish;
    end

endmodule
